/* rtl/ppo_pkg.sv */
// ----------------------------------------------------------------------------
// Pulse pair odometry package
// Shared widths, codes, item and command types, and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ppo_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int ATAN_IDX_W       = 5;

    localparam int DIST_W     = 24;
    localparam int ANG_CFG_W  = 15;
    localparam int POS_W      = 32;
    localparam int HDG_W      = 16;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    // CORDIC vectors carry 30 fraction bits plus growth headroom
    localparam int CORDIC_W = 34;
    localparam int ZANG_W   = 32;
    localparam int PROD_W   = DIST_W + 1 + POS_W;
    localparam int SUM_W    = 63;

    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sh26DD3B6A;

    localparam logic [KIND_W-1:0] KIND_NONE       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FORWARD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TURN_LEFT  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TURN_RIGHT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DISTANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_ANGLE    = 2'd1;

    localparam logic [DIST_W-1:0]    STEP_DISTANCE_RST = 24'd65536;
    localparam logic [ANG_CFG_W-1:0] STEP_ANGLE_RST    = 15'd512;

    typedef struct packed {
        logic req_type;
        logic pulse_level;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic [HDG_W-1:0]        heading;
        logic [KIND_W-1:0]       move_kind;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_item;

    typedef struct packed {
        logic rot1;
        logic rot2;
        logic turn_left;
        logic cordic_init;
        logic cordic_iter;
        logic cordic_fix;
        logic mul_x;
        logic mul_y;
        logic add_y;
        logic half_shift;
        logic set_left;
        logic set_right;
        logic clr_flags;
    } t_dp_cmd;

    typedef struct packed {
        logic left_seen;
        logic right_seen;
        logic iter_last;
    } t_dp_status;

    function automatic logic [ZANG_W-1:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
        logic [ZANG_W-1:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

/* rtl/ppo_in_if.sv */
// ----------------------------------------------------------------------------
// Pulse input channel
// Valid/ready channel carrying one wheel pulse event per item.
// ----------------------------------------------------------------------------
interface ppo_in_if;
    logic              valid;
    logic              ready;
    ppo_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/ppo_out_if.sv */
// ----------------------------------------------------------------------------
// Pose output channel
// Valid/ready channel carrying the pose and move kind for each item.
// ----------------------------------------------------------------------------
interface ppo_out_if;
    logic               valid;
    logic               ready;
    ppo_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/ppo_cfg_if.sv */
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface ppo_cfg_if;
    logic               valid;
    logic               ready;
    ppo_pkg::t_cfg_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/pulse_pair_odometry_top.sv */
// From accept: a pulse that moves nothing goes to DONE; a forward step runs
//   INIT, ITER, FIX, MULX, MULY and ADDY; a turn adds ROT1 before, ROT2 after.
// Throughput: one item at a time, set by the CORDIC iterations and the shared
//   multiplier; the next item is accepted in the cycle after the result is
//   written, while the output register still holds it.
// Reset (synchronous, active low) clears pose and flags and loads step defaults.
// ----------------------------------------------------------------------------
// Pulse pair odometry top level
// Configuration registers, output register, controller and datapath.
// ----------------------------------------------------------------------------
module pulse_pair_odometry_top #(
    parameter int CORDIC_STEPS = ppo_pkg::CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ppo_in_if.sink       i_in,
    ppo_out_if.source    o_out,
    ppo_cfg_if.sink      i_cfg
);

    logic [ppo_pkg::DIST_W-1:0]    r_step_distance;
    logic [ppo_pkg::ANG_CFG_W-1:0] r_step_angle;
    logic                          r_out_valid;
    ppo_pkg::t_out_item            r_out;

    ppo_pkg::t_dp_cmd              w_cmd;
    ppo_pkg::t_dp_status           w_status;
    logic                          w_start, w_emit, w_out_free, w_ready;
    logic [ppo_pkg::KIND_W-1:0]    w_kind;
    logic signed [ppo_pkg::POS_W-1:0] w_pos_x, w_pos_y;
    logic [ppo_pkg::HDG_W-1:0]     w_heading;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_ready;
    assign w_start     = i_in.valid && w_ready;
    assign w_out_free  = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_distance <= ppo_pkg::STEP_DISTANCE_RST;
            r_step_angle    <= ppo_pkg::STEP_ANGLE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.data.index)
                ppo_pkg::CFG_STEP_DISTANCE: r_step_distance <= i_cfg.data.data;
                ppo_pkg::CFG_STEP_ANGLE:
                    r_step_angle <= i_cfg.data.data[ppo_pkg::ANG_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.pos_x     <= w_pos_x;
            r_out.pos_y     <= w_pos_y;
            r_out.heading   <= w_heading;
            r_out.move_kind <= w_kind;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    ppo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_item     (i_in.data),
        .i_status   (w_status),
        .i_out_free (w_out_free),
        .o_ready    (w_ready),
        .o_emit     (w_emit),
        .o_kind     (w_kind),
        .o_cmd      (w_cmd)
    );

    ppo_dp #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_step_distance (r_step_distance),
        .i_step_angle    (r_step_angle),
        .o_status        (w_status),
        .o_pos_x         (w_pos_x),
        .o_pos_y         (w_pos_y),
        .o_heading       (w_heading)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !w_ready)
        else $error("controller took a second item while busy");

    a_emit_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |-> w_out_free)
        else $error("result written over an undelivered item");

    a_idle_no_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ready |-> !w_emit)
        else $error("result emitted while controller idle");

    a_first_pulse_no_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.set_left || w_cmd.set_right) |=> $stable(w_heading) && $stable(w_pos_x))
        else $error("pose changed on a first pulse");

endmodule

/* rtl/ppo_ctrl.sv */
// ----------------------------------------------------------------------------
// Odometry controller
// Decodes each pulse against the seen flags and sequences the datapath.
// ----------------------------------------------------------------------------
module ppo_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  ppo_pkg::t_in_item           i_item,
    input  ppo_pkg::t_dp_status         i_status,
    input  logic                        i_out_free,
    output logic                        o_ready,
    output logic                        o_emit,
    output logic [ppo_pkg::KIND_W-1:0]  o_kind,
    output ppo_pkg::t_dp_cmd            o_cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_ROT1 = 4'd1;
    localparam logic [3:0] ST_INIT = 4'd2;
    localparam logic [3:0] ST_ITER = 4'd3;
    localparam logic [3:0] ST_FIX  = 4'd4;
    localparam logic [3:0] ST_MULX = 4'd5;
    localparam logic [3:0] ST_MULY = 4'd6;
    localparam logic [3:0] ST_ADDY = 4'd7;
    localparam logic [3:0] ST_ROT2 = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    logic [3:0]                 r_state, n_state;
    logic [ppo_pkg::KIND_W-1:0] r_kind, n_kind;

    logic w_own, w_other, w_act;

    assign w_own   = i_item.req_type ? i_status.right_seen : i_status.left_seen;
    assign w_other = i_item.req_type ? i_status.left_seen  : i_status.right_seen;
    assign w_act   = i_start && i_item.pulse_level;

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_ready = 1'b0;
        o_emit  = 1'b0;
        o_cmd   = '0;
        o_cmd.turn_left  = (r_kind == ppo_pkg::KIND_TURN_LEFT);
        o_cmd.half_shift = (r_kind != ppo_pkg::KIND_FORWARD);
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_start) begin
                    n_kind  = ppo_pkg::KIND_NONE;
                    n_state = ST_DONE;
                    if (w_act && w_own) begin
                        n_kind  = i_item.req_type ? ppo_pkg::KIND_TURN_LEFT
                                                  : ppo_pkg::KIND_TURN_RIGHT;
                        n_state = ST_ROT1;
                    end else if (w_act && w_other) begin
                        n_kind  = ppo_pkg::KIND_FORWARD;
                        n_state = ST_INIT;
                    end
                end
                // first pulse of a wheel: mark it and report no move
                o_cmd.set_left  = w_act && !w_own && !w_other && !i_item.req_type;
                o_cmd.set_right = w_act && !w_own && !w_other && i_item.req_type;
            end
            ST_ROT1: begin
                o_cmd.rot1 = 1'b1;
                n_state    = ST_INIT;
            end
            ST_INIT: begin
                o_cmd.cordic_init = 1'b1;
                n_state           = ST_ITER;
            end
            ST_ITER: begin
                o_cmd.cordic_iter = 1'b1;
                if (i_status.iter_last) begin
                    n_state = ST_FIX;
                end
            end
            ST_FIX: begin
                o_cmd.cordic_fix = 1'b1;
                n_state          = ST_MULX;
            end
            ST_MULX: begin
                o_cmd.mul_x = 1'b1;
                n_state     = ST_MULY;
            end
            ST_MULY: begin
                o_cmd.mul_y = 1'b1;
                n_state     = ST_ADDY;
            end
            ST_ADDY: begin
                o_cmd.add_y = 1'b1;
                if (r_kind == ppo_pkg::KIND_FORWARD) begin
                    o_cmd.clr_flags = 1'b1;
                    n_state         = ST_DONE;
                end else begin
                    n_state = ST_ROT2;
                end
            end
            ST_ROT2: begin
                o_cmd.rot2 = 1'b1;
                n_state    = ST_DONE;
            end
            ST_DONE: begin
                // hold until the output register can take the item
                if (i_out_free) begin
                    o_emit  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_kind  <= ppo_pkg::KIND_NONE;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

    assign o_kind = r_kind;

endmodule

/* rtl/ppo_dp.sv */
// ----------------------------------------------------------------------------
// Odometry datapath
// Pose and flag registers, iterative CORDIC sin/cos, shared step multiplier.
// ----------------------------------------------------------------------------
module ppo_dp #(
    parameter int CORDIC_STEPS = ppo_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ppo_pkg::t_dp_cmd                    i_cmd,
    input  logic [ppo_pkg::DIST_W-1:0]          i_step_distance,
    input  logic [ppo_pkg::ANG_CFG_W-1:0]       i_step_angle,
    output ppo_pkg::t_dp_status                 o_status,
    output logic signed [ppo_pkg::POS_W-1:0]    o_pos_x,
    output logic signed [ppo_pkg::POS_W-1:0]    o_pos_y,
    output logic [ppo_pkg::HDG_W-1:0]           o_heading
);

    localparam int IW = ppo_pkg::ATAN_IDX_W;
    localparam int CW = ppo_pkg::CORDIC_W;
    localparam int PW = ppo_pkg::POS_W;
    localparam int HW = ppo_pkg::HDG_W;
    localparam int SW = ppo_pkg::SUM_W;
    localparam logic [IW-1:0] IDX_LAST = IW'(CORDIC_STEPS - 1);

    logic                            r_left_seen, r_right_seen;
    logic [PW-1:0]                   r_x_pos, r_y_pos;
    logic [HW-1:0]                   r_hdg;
    logic signed [CW-1:0]            r_cx, r_cy;
    logic [ppo_pkg::ZANG_W-1:0]      r_z;
    logic                            r_flip;
    logic [IW-1:0]                   r_idx;
    logic signed [ppo_pkg::PROD_W-1:0] r_prod;

    logic [HW-1:0]                   w_first, w_second, w_rot_amt;
    logic signed [CW-1:0]            w_xs, w_ys;
    logic [ppo_pkg::ZANG_W-1:0]      w_atan;
    logic                            w_quad_flip;
    logic signed [PW-1:0]            w_mul_b;
    logic signed [ppo_pkg::PROD_W-1:0] w_mul;
    logic [SW-1:0]                   w_sum;
    logic [PW-1:0]                   w_round;

    // split the turn so the two halves add up to the full step angle
    assign w_first   = HW'(i_step_angle >> 1);
    assign w_second  = HW'(i_step_angle) - w_first;
    assign w_rot_amt = i_cmd.rot1 ? w_first : w_second;

    assign w_xs   = r_cx >>> r_idx;
    assign w_ys   = r_cy >>> r_idx;
    assign w_atan = ppo_pkg::atan_lut(r_idx);
    assign w_quad_flip = r_hdg[HW-1] ^ r_hdg[HW-2];

    assign w_mul_b = i_cmd.mul_x ? r_cx[PW-1:0] : r_cy[PW-1:0];
    assign w_mul   = $signed({1'b0, i_step_distance}) * w_mul_b;

    // round half up, then take 32 bits at the step's binary point
    assign w_sum   = SW'(r_prod) + (i_cmd.half_shift ? (SW'(1) << 30) : (SW'(1) << 29));
    assign w_round = i_cmd.half_shift ? w_sum[62:31] : w_sum[61:30];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_seen  <= 1'b0;
            r_right_seen <= 1'b0;
            r_x_pos      <= '0;
            r_y_pos      <= '0;
            r_hdg        <= '0;
            r_idx        <= '0;
        end else begin
            if (i_cmd.set_left) begin
                r_left_seen <= 1'b1;
            end
            if (i_cmd.set_right) begin
                r_right_seen <= 1'b1;
            end
            if (i_cmd.clr_flags) begin
                r_left_seen  <= 1'b0;
                r_right_seen <= 1'b0;
            end
            if (i_cmd.rot1 || i_cmd.rot2) begin
                r_hdg <= i_cmd.turn_left ? r_hdg + w_rot_amt : r_hdg - w_rot_amt;
            end
            if (i_cmd.cordic_init) begin
                r_idx <= '0;
            end else if (i_cmd.cordic_iter) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.mul_y) begin
                r_x_pos <= r_x_pos + w_round;
            end
            if (i_cmd.add_y) begin
                r_y_pos <= r_y_pos + w_round;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cordic_init) begin
            // fold the second and third quadrant by half a turn
            r_flip <= w_quad_flip;
            r_z    <= {r_hdg, 16'b0} ^ {w_quad_flip, 31'b0};
            r_cx   <= ppo_pkg::CORDIC_GAIN;
            r_cy   <= '0;
        end else if (i_cmd.cordic_iter) begin
            if (!r_z[ppo_pkg::ZANG_W-1]) begin
                r_cx <= r_cx - w_ys;
                r_cy <= r_cy + w_xs;
                r_z  <= r_z - w_atan;
            end else begin
                r_cx <= r_cx + w_ys;
                r_cy <= r_cy - w_xs;
                r_z  <= r_z + w_atan;
            end
        end else if (i_cmd.cordic_fix && r_flip) begin
            r_cx <= -r_cx;
            r_cy <= -r_cy;
        end
        if (i_cmd.mul_x || i_cmd.mul_y) begin
            r_prod <= w_mul;
        end
    end

    assign o_status.left_seen  = r_left_seen;
    assign o_status.right_seen = r_right_seen;
    assign o_status.iter_last  = (r_idx == IDX_LAST);
    assign o_pos_x   = r_x_pos;
    assign o_pos_y   = r_y_pos;
    assign o_heading = r_hdg;

endmodule

/* dv/tb_pulse_pair_odometry_top.sv */
// ----------------------------------------------------------------------------
// Pulse pair odometry testbench
// Feeds wheel pulse items and register writes into the block, predicts the
// pose after every item with a cycle-free CORDIC model of its own, and checks
// each pose item field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_pulse_pair_odometry_top;

    localparam int CORDIC_ITERS   = ppo_pkg::CORDIC_STEPS_DEF;
    localparam int SETTLE_CYCLES  = CORDIC_ITERS + 16;
    localparam int N_PHASES       = 6;
    localparam int PHASE_ITEMS    = 225;
    localparam int CYCLE_LIMIT    = 600000;
    localparam int N_DIR          = 29;

    localparam logic WHEEL_LEFT  = 1'b0;
    localparam logic WHEEL_RIGHT = 1'b1;
    localparam logic PULSE_LOW   = 1'b0;
    localparam logic PULSE_HIGH  = 1'b1;

    // indexes past the register file, writes to them must be dropped
    localparam logic [ppo_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [ppo_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam logic [ppo_pkg::DIST_W-1:0]    DIST_MAX  = 24'hFFFFFF;
    localparam logic [ppo_pkg::ANG_CFG_W-1:0] ANGLE_MAX = 15'h7FFF;

    localparam logic signed [63:0] Q30_GAIN = 64'sh26DD3B6A;

    localparam ppo_pkg::t_out_item POSE_AT_ORIGIN = '{pos_x: '0, pos_y: '0, heading: '0,
                                                      move_kind: ppo_pkg::KIND_NONE};

    localparam logic [31:0] ARCTAN_Q32 [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef enum logic {ROW_PULSE, ROW_WRITE} t_row_op;

    typedef struct {
        t_row_op                       op;
        logic                          wheel;
        logic                          level;
        logic [ppo_pkg::CFG_IDX_W-1:0] idx;
        logic [ppo_pkg::DIST_W-1:0]    val;
        bit                            chk;
        ppo_pkg::t_out_item            pose;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ppo_in_if  pulse_ch ();
    ppo_out_if pose_ch ();
    ppo_cfg_if reg_ch ();

    pulse_pair_odometry_top #(
        .CORDIC_STEPS(CORDIC_ITERS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (pulse_ch),
        .o_out  (pose_ch),
        .i_cfg  (reg_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predicted block state
    logic [ppo_pkg::DIST_W-1:0]    step_dist;
    logic [ppo_pkg::ANG_CFG_W-1:0] step_ang;
    logic [ppo_pkg::POS_W-1:0]     odo_x;
    logic [ppo_pkg::POS_W-1:0]     odo_y;
    logic [ppo_pkg::HDG_W-1:0]     odo_hdg;
    logic                          left_seen;
    logic                          right_seen;

    ppo_pkg::t_out_item pose_q[$];
    int        mismatches = 0;
    int        cycle_cnt  = 0;
    int        stall_left = 0;
    int        stall_mode = 0;

    t_dir_row dir_rows [N_DIR];

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // rotation-mode CORDIC, second and third quadrant folded by half a turn
    function automatic void odo_sincos(input logic [ppo_pkg::HDG_W-1:0] ang,
                                       output longint c, output longint s);
        logic [31:0] z;
        logic        flip;
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        z    = {ang, 16'h0000};
        flip = ang[15] ^ ang[14];
        x    = Q30_GAIN;
        y    = 0;
        if (flip) begin
            z = z - 32'h80000000;
        end
        for (int i = 0; i < CORDIC_ITERS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (!z[31]) begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN_Q32[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN_Q32[i];
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = x;
        s = y;
    endfunction

    // shift 30 for a full step, 31 for a half step; round half up
    function automatic void odo_advance(input int shift);
        longint c;
        longint s;
        longint d;
        longint half;
        longint dx;
        longint dy;
        odo_sincos(odo_hdg, c, s);
        d    = longint'({40'd0, step_dist});
        half = longint'(1) <<< (shift - 1);
        dx   = (d * c + half) >>> shift;
        dy   = (d * s + half) >>> shift;
        odo_x = odo_x + dx[31:0];
        odo_y = odo_y + dy[31:0];
    endfunction

    function automatic void odo_turn(input logic to_left);
        logic [ppo_pkg::HDG_W-1:0] first_half;
        logic [ppo_pkg::HDG_W-1:0] second_half;
        first_half  = {1'b0, step_ang} >> 1;
        second_half = {1'b0, step_ang} - first_half;
        odo_hdg = to_left ? odo_hdg + first_half : odo_hdg - first_half;
        odo_advance(31);
        odo_hdg = to_left ? odo_hdg + second_half : odo_hdg - second_half;
    endfunction

    function automatic ppo_pkg::t_out_item odo_pulse(input logic wheel, input logic level);
        ppo_pkg::t_out_item         res;
        logic                       own;
        logic                       other;
        logic [ppo_pkg::KIND_W-1:0] kind;
        kind = ppo_pkg::KIND_NONE;
        if (level) begin
            own   = wheel ? right_seen : left_seen;
            other = wheel ? left_seen : right_seen;
            if (own) begin
                // repeated pulse turns away from its wheel
                odo_turn(wheel);
                kind = wheel ? ppo_pkg::KIND_TURN_LEFT : ppo_pkg::KIND_TURN_RIGHT;
            end else if (other) begin
                odo_advance(30);
                left_seen  = 1'b0;
                right_seen = 1'b0;
                kind = ppo_pkg::KIND_FORWARD;
            end else if (wheel) begin
                right_seen = 1'b1;
            end else begin
                left_seen = 1'b1;
            end
        end
        res.pos_x     = odo_x;
        res.pos_y     = odo_y;
        res.heading   = odo_hdg;
        res.move_kind = kind;
        return res;
    endfunction

    function automatic void odo_config(input logic [ppo_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [ppo_pkg::DIST_W-1:0] val);
        case (idx)
            ppo_pkg::CFG_STEP_DISTANCE: step_dist = val;
            ppo_pkg::CFG_STEP_ANGLE:    step_ang  = val[ppo_pkg::ANG_CFG_W-1:0];
            default: ;
        endcase
    endfunction

    // leaves valid high so the next item can follow back to back
    task automatic send_pulse(input logic wheel, input logic level,
                              input bit chk, input ppo_pkg::t_out_item pose);
        ppo_pkg::t_out_item predicted;
        pulse_ch.valid <= 1'b1;
        pulse_ch.data  <= '{req_type: wheel, pulse_level: level};
        do @(posedge i_clk); while (!pulse_ch.ready);
        predicted = odo_pulse(wheel, level);
        pose_q.push_back(chk ? pose : predicted);
    endtask

    task automatic go_idle(input int gap);
        if (gap > 0) begin
            pulse_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // pulse valid must already be low; write only once the block has drained
    task automatic write_reg(input logic [ppo_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ppo_pkg::DIST_W-1:0] val);
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        reg_ch.valid <= 1'b1;
        reg_ch.data  <= '{index: idx, data: val};
        do @(posedge i_clk); while (!reg_ch.ready);
        odo_config(idx, val);
        reg_ch.valid <= 1'b0;
    endtask

    function automatic logic [ppo_pkg::DIST_W-1:0] pick_dist();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return DIST_MAX;
            2:       return ppo_pkg::STEP_DISTANCE_RST;
            default: return ppo_pkg::DIST_W'($urandom_range(0, 32'hFFFFFF));
        endcase
    endfunction

    function automatic logic [ppo_pkg::DIST_W-1:0] pick_angle();
        logic [8:0] junk;
        junk = 9'($urandom_range(0, 511));
        case ($urandom_range(0, 3))
            0:       return {junk, 15'd0};
            1:       return {junk, ANGLE_MAX};
            2:       return {9'd0, ppo_pkg::STEP_ANGLE_RST};
            default: return {junk, 15'($urandom_range(0, 32767))};
        endcase
    endfunction

    // receiver stalls and result checking
    always @(posedge i_clk) begin
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("** pulse_pair_odometry_top: FAILED **");
            $finish;
        end else begin
            cycle_cnt <= cycle_cnt + 1;
            if (stall_left == 0) begin
                stall_mode <= $urandom_range(0, 3);
                stall_left <= $urandom_range(16, 80);
            end else begin
                stall_left <= stall_left - 1;
            end
            case (stall_mode)
                0:       pose_ch.ready <= 1'b1;
                1:       pose_ch.ready <= 1'($urandom_range(0, 1));
                2:       pose_ch.ready <= ($urandom_range(0, 5) == 0);
                default: pose_ch.ready <= (cycle_cnt % 4 != 0);
            endcase
            if (i_rst_n && pose_ch.valid && pose_ch.ready) begin
                if (pose_q.size() == 0) begin
                    report_mismatch("pose item with none pending", pose_ch.data.pos_x, 0);
                end else begin
                    if (pose_ch.data.pos_x !== pose_q[0].pos_x)
                        report_mismatch("pos_x", pose_ch.data.pos_x, pose_q[0].pos_x);
                    if (pose_ch.data.pos_y !== pose_q[0].pos_y)
                        report_mismatch("pos_y", pose_ch.data.pos_y, pose_q[0].pos_y);
                    if (pose_ch.data.heading !== pose_q[0].heading)
                        report_mismatch("heading", pose_ch.data.heading, pose_q[0].heading);
                    if (pose_ch.data.move_kind !== pose_q[0].move_kind)
                        report_mismatch("move_kind", pose_ch.data.move_kind,
                                        pose_q[0].move_kind);
                    void'(pose_q.pop_front());
                end
            end
        end
    end

    initial begin
        int       sent;
        int       burst;
        int       gap;
        t_dir_row row;

        dir_rows = '{
            '{ROW_PULSE, WHEEL_LEFT,  PULSE_LOW,  '0, '0, 1'b1, POSE_AT_ORIGIN},
            '{ROW_PULSE, WHEEL_RIGHT, PULSE_LOW,  '0, '0, 1'b1, POSE_AT_ORIGIN},
            '{ROW_PULSE, WHEEL_LEFT,  PULSE_HIGH, '0, '0, 1'b1, POSE_AT_ORIGIN},
            '{ROW_PULSE, WHEEL_RIGHT, PULSE_HIGH, '0, '0, 1'b0, POSE_AT_ORIGIN},
            '{ROW_PULSE, WHEEL_RIGHT, PULSE_HIGH, '0, '0, 1'b0, POSE_AT_ORIGIN},
            '{ROW_PULSE, WHEEL_RIGHT, PULSE_HIGH, '0, '0, 1'b0, POSE_AT_ORIGIN},
            '{ROW_PULSE, WHEEL_LEFT,  PULSE_HIGH, '0, '0, 1'b0, POSE_AT_ORIGIN},
            '{ROW_PULSE, WHEEL_LEFT,  PULSE_HIGH, '0, '0, 1'b0, POSE_AT_ORIGIN},
            '{ROW_PULSE, WHEEL_LEFT,  PULSE_HIGH, '0, '0, 1'b0, POSE_AT_ORIGIN},
            '{ROW_PULSE, WHEEL_LEFT,  PULSE_HIGH, '0, '0, 1'b0, POSE_AT_ORIGIN},
            // upper data bits must be masked off, leaving the largest odd angle
            '{ROW_WRITE, WHEEL_LEFT,  PULSE_LOW,  ppo_pkg::CFG_STEP_ANGLE, DIST_MAX, 1'b0,
              POSE_AT_ORIGIN},
            '{ROW_PULSE, WHEEL_RIGHT, PULSE_HIGH, '0, '0, 1'b0, POSE_AT_ORIGIN},
            '{ROW_PULSE, WHEEL_RIGHT, PULSE_HIGH, '0, '0, 1'b0, POSE_AT_ORIGIN},
            '{ROW_PULSE, WHEEL_RIGHT, PULSE_HIGH, '0, '0, 1'b0, POSE_AT_ORIGIN},
            '{ROW_PULSE, WHEEL_RIGHT, PULSE_HIGH, '0, '0, 1'b0, POSE_AT_ORIGIN},
            '{ROW_WRITE, WHEEL_LEFT,  PULSE_LOW,  ppo_pkg::CFG_STEP_DISTANCE, DIST_MAX, 1'b0,
              POSE_AT_ORIGIN},
            '{ROW_WRITE, WHEEL_LEFT,  PULSE_LOW,  CFG_SPARE_A, DIST_MAX, 1'b0,
              POSE_AT_ORIGIN},
            '{ROW_WRITE, WHEEL_LEFT,  PULSE_LOW,  CFG_SPARE_B, 24'h000001, 1'b0,
              POSE_AT_ORIGIN},
            '{ROW_PULSE, WHEEL_LEFT,  PULSE_HIGH, '0, '0, 1'b0, POSE_AT_ORIGIN},
            '{ROW_PULSE, WHEEL_LEFT,  PULSE_HIGH, '0, '0, 1'b0, POSE_AT_ORIGIN},
            '{ROW_PULSE, WHEEL_LEFT,  PULSE_HIGH, '0, '0, 1'b0, POSE_AT_ORIGIN},
            '{ROW_WRITE, WHEEL_LEFT,  PULSE_LOW,  ppo_pkg::CFG_STEP_DISTANCE, '0, 1'b0,
              POSE_AT_ORIGIN},
            '{ROW_WRITE, WHEEL_LEFT,  PULSE_LOW,  ppo_pkg::CFG_STEP_ANGLE, '0, 1'b0,
              POSE_AT_ORIGIN},
            '{ROW_PULSE, WHEEL_RIGHT, PULSE_HIGH, '0, '0, 1'b0, POSE_AT_ORIGIN},
            '{ROW_PULSE, WHEEL_RIGHT, PULSE_HIGH, '0, '0, 1'b0, POSE_AT_ORIGIN},
            '{ROW_PULSE, WHEEL_RIGHT, PULSE_HIGH, '0, '0, 1'b0, POSE_AT_ORIGIN},
            '{ROW_PULSE, WHEEL_LEFT,  PULSE_LOW,  '0, '0, 1'b0, POSE_AT_ORIGIN},
            '{ROW_WRITE, WHEEL_LEFT,  PULSE_LOW,  ppo_pkg::CFG_STEP_DISTANCE,
              ppo_pkg::STEP_DISTANCE_RST, 1'b0, POSE_AT_ORIGIN},
            '{ROW_WRITE, WHEEL_LEFT,  PULSE_LOW,  ppo_pkg::CFG_STEP_ANGLE,
              {9'd0, ppo_pkg::STEP_ANGLE_RST}, 1'b0, POSE_AT_ORIGIN}
        };

        step_dist  = ppo_pkg::STEP_DISTANCE_RST;
        step_ang   = ppo_pkg::STEP_ANGLE_RST;
        odo_x      = '0;
        odo_y      = '0;
        odo_hdg    = '0;
        left_seen  = 1'b0;
        right_seen = 1'b0;

        i_rst_n        <= 1'b0;
        pulse_ch.valid <= 1'b0;
        pulse_ch.data  <= '0;
        reg_ch.valid   <= 1'b0;
        reg_ch.data    <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            if (row.op == ROW_WRITE) begin
                go_idle(1);
                write_reg(row.idx, row.val);
            end else begin
                send_pulse(row.wheel, row.level, row.chk, row.pose);
                go_idle($urandom_range(0, 3));
            end
        end
        go_idle(1);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            // first phase runs at the largest step and angle to force wraps early
            write_reg(ppo_pkg::CFG_STEP_DISTANCE, ph == 0 ? DIST_MAX : pick_dist());
            write_reg(ppo_pkg::CFG_STEP_ANGLE, ph == 0 ? {9'd0, ANGLE_MAX} : pick_angle());
            if ($urandom_range(0, 1) == 1) begin
                write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                          ppo_pkg::DIST_W'($urandom_range(0, 32'hFFFFFF)));
            end
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                burst = $urandom_range(1, 16);
                for (int b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
                    send_pulse(1'($urandom_range(0, 1)), ($urandom_range(0, 9) != 0),
                               1'b0, POSE_AT_ORIGIN);
                    sent++;
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                go_idle(gap);
            end
            go_idle(1);
        end

        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("** pulse_pair_odometry_top: PASSED **");
        end else begin
            $display("** pulse_pair_odometry_top: FAILED **");
        end
        $finish;
    end

endmodule
